// ===== rtl/core/gpbd_pkg.sv =====
package gpbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W  = 11;
  localparam int LEN_W  = 12;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [7:0] CMD_COLOUR_BASE  = 8'hC0;
  localparam logic [7:0] CMD_BLOCK_TOOL   = 8'h82;
  localparam logic [7:0] CMD_SET_RGBA     = 8'h83;
  localparam logic [7:0] CMD_TARGETX_ZERO = 8'h84;
  localparam logic [7:0] CMD_DOWN_ONE     = 8'h41;
  localparam logic [7:0] CMD_UP_ONE       = 8'h7F;
  localparam logic [7:0] CMD_ALPHA_FULL   = 8'hFF;
  localparam logic [7:0] MOVE_STEP        = 8'd31;
  localparam logic [1:0] ALPHA_LOW_BITS   = 2'b11;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic             tool;
    logic             changed;
    logic             last;
    logic [7:0]       grey;
    logic [LEN_W-1:0] len;
  } cmd_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

  function automatic logic [7:0] colour_byte(input logic [2:0] idx, input logic [7:0] g);
    logic [5:0] p;
    unique case (idx)
      3'd0: p = {4'd0, g[7:6]};
      3'd1: p = g[5:0];
      3'd2: p = g[7:2];
      3'd3: p = {g[1:0], g[7:4]};
      default: p = {g[3:0], ALPHA_LOW_BITS};
    endcase
    return CMD_COLOUR_BASE | {2'b00, p};
  endfunction

endpackage

// ===== rtl/core/grey_pixels_to_block_draw_commands.sv =====
// channel   direction  transfer when        payload
// pixel     in         push && !full        pixel_value
// command   out        pop && !empty        out_byte, last_of_run
// config    in         cfg_we               cfg_index, cfg_data
//
// one output byte per cycle while pop stays high and commands are waiting; a pixel
// causes up to 45 bytes, or none, all made by the back-end byte sequencer;
// an idle back end loads the next command before it emits that command's first byte
// synchronous active-high rst clears counters, queue and output valid; sizes reset to 1
// a four-entry command queue lets pixels keep arriving while pop is held low
module grey_pixels_to_block_draw_commands (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [gpbd_pkg::DIM_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  pixel_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        last_of_run
);

  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  gpbd_pkg::cmd_t q_wr_data;
  gpbd_pkg::cmd_t q_rd_data;

  gpbd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .pixel_value (pixel_value),
    .q_full      (full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  gpbd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_wr_data),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  gpbd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== rtl/core/gpbd_front.sv =====
module gpbd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [gpbd_pkg::DIM_W-1:0]   cfg_data,
  input  logic                         push,
  input  logic [7:0]                   pixel_value,
  input  logic                         q_full,
  output logic                         q_push,
  output gpbd_pkg::cmd_t               q_data
);

  logic [gpbd_pkg::DIM_W-1:0] image_width;
  logic [gpbd_pkg::DIM_W-1:0] image_height;
  logic [8:0]                 previous_grey;
  logic [gpbd_pkg::DIM_W-1:0] run_width;
  logic [gpbd_pkg::DIM_W-1:0] column_count;
  logic [gpbd_pkg::DIM_W-1:0] row_count;

  logic [gpbd_pkg::DIM_W-1:0] w;
  logic [gpbd_pkg::DIM_W-1:0] h;
  logic                       accept;
  logic                       first_col;
  logic                       last_col;
  logic                       last_row;
  logic                       frame_start;
  logic [8:0]                 prev_eff;
  logic                       changed;
  logic                       draw;
  logic [gpbd_pkg::DIM_W-1:0] run_width_next;

  assign w = gpbd_pkg::clamp_size(image_width, gpbd_pkg::DIM_W'(gpbd_pkg::MAX_WIDTH));
  assign h = gpbd_pkg::clamp_size(image_height, gpbd_pkg::DIM_W'(gpbd_pkg::MAX_HEIGHT));

  assign accept      = push && !q_full;
  assign first_col   = (column_count == '0);
  assign last_col    = ({1'b0, column_count} + 12'd1) >= {1'b0, w};
  assign last_row    = ({1'b0, row_count} + 12'd1) >= {1'b0, h};
  assign frame_start = first_col && (row_count == '0);
  assign prev_eff    = frame_start ? 9'd256 : previous_grey;
  assign changed     = prev_eff != {1'b0, pixel_value};
  assign draw        = changed || first_col || last_col;

  always_comb begin
    if (last_col) run_width_next = '0;
    else if (draw) run_width_next = gpbd_pkg::DIM_W'(1);
    else run_width_next = run_width + gpbd_pkg::DIM_W'(1);
  end

  assign q_push         = accept && (draw || frame_start);
  assign q_data.tool    = frame_start;
  assign q_data.changed = changed;
  assign q_data.last    = last_col;
  assign q_data.grey    = pixel_value;
  assign q_data.len     = {1'b0, run_width} + (last_col ? 12'd1 : 12'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= gpbd_pkg::DIM_W'(1);
      image_height  <= gpbd_pkg::DIM_W'(1);
      previous_grey <= 9'd256;
      run_width     <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gpbd_pkg::REG_IMAGE_WIDTH) image_width <= cfg_data;
        else if (cfg_index == gpbd_pkg::REG_IMAGE_HEIGHT) image_height <= cfg_data;
      end
      if (accept) begin
        previous_grey <= {1'b0, pixel_value};
        run_width     <= run_width_next;
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_count + gpbd_pkg::DIM_W'(1);
        end else begin
          column_count <= column_count + gpbd_pkg::DIM_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/gpbd_cmd_fifo.sv =====
module gpbd_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  gpbd_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output logic           rd_valid,
  output gpbd_pkg::cmd_t rd_data
);

  gpbd_pkg::cmd_t                 mem [gpbd_pkg::QDEPTH];
  logic [gpbd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [gpbd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [gpbd_pkg::QPTR_W:0]      count;
  logic                           do_wr;
  logic                           do_rd;

  assign full     = count == (gpbd_pkg::QPTR_W+1)'(gpbd_pkg::QDEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + gpbd_pkg::QPTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + gpbd_pkg::QPTR_W'(1);
      if (do_wr && !do_rd) count <= count + (gpbd_pkg::QPTR_W+1)'(1);
      else if (do_rd && !do_wr) count <= count - (gpbd_pkg::QPTR_W+1)'(1);
    end
  end

endmodule

// ===== rtl/core/gpbd_back.sv =====
module gpbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  gpbd_pkg::cmd_t q_data,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOOL  = 4'd1;
  localparam logic [3:0] S_MOVE  = 4'd2;
  localparam logic [3:0] S_DRAW1 = 4'd3;
  localparam logic [3:0] S_DRAW2 = 4'd4;
  localparam logic [3:0] S_C0    = 4'd5;
  localparam logic [3:0] S_C1    = 4'd6;
  localparam logic [3:0] S_C2    = 4'd7;
  localparam logic [3:0] S_C3    = 4'd8;
  localparam logic [3:0] S_C4    = 4'd9;
  localparam logic [3:0] S_ALPHA = 4'd10;
  localparam logic [3:0] S_SET   = 4'd11;
  localparam logic [3:0] S_NL1   = 4'd12;
  localparam logic [3:0] S_NL2   = 4'd13;

  gpbd_pkg::cmd_t                cmd;
  logic [3:0]                    step;
  logic [3:0]                    step_next;
  logic [3:0]                    step_start;
  logic [gpbd_pkg::LEN_W-1:0]    rem;
  logic [gpbd_pkg::LEN_W-1:0]    rem_next;
  logic [7:0]                    byte_next;
  logic                          out_valid;
  logic                          advance;
  logic                          load;
  logic                          move_full;
  logic [3:0]                    after_set;

  assign empty     = !out_valid;
  assign advance   = (step != S_IDLE) && (!out_valid || pop);
  assign load      = q_valid && ((step == S_IDLE) || (advance && step_next == S_IDLE));
  assign q_pop     = load;
  assign move_full = rem >= gpbd_pkg::LEN_W'(gpbd_pkg::MOVE_STEP);
  assign after_set = cmd.last ? S_NL1 : S_IDLE;

  always_comb begin
    if (q_data.tool) step_start = S_TOOL;
    else if (q_data.len != '0) step_start = S_MOVE;
    else step_start = S_DRAW1;
  end

  always_comb begin
    rem_next  = rem;
    byte_next = gpbd_pkg::CMD_DOWN_ONE;
    step_next = S_IDLE;
    unique case (step)
      S_TOOL: begin
        byte_next = gpbd_pkg::CMD_BLOCK_TOOL;
        step_next = (rem != '0) ? S_MOVE : S_DRAW1;
      end
      S_MOVE: begin
        if (move_full) begin
          byte_next = gpbd_pkg::MOVE_STEP;
          rem_next  = rem - gpbd_pkg::LEN_W'(gpbd_pkg::MOVE_STEP);
        end else begin
          byte_next = rem[7:0];
          rem_next  = '0;
        end
        step_next = (rem_next != '0) ? S_MOVE : S_DRAW1;
      end
      S_DRAW1: begin
        byte_next = gpbd_pkg::CMD_DOWN_ONE;
        step_next = S_DRAW2;
      end
      S_DRAW2: begin
        byte_next = gpbd_pkg::CMD_UP_ONE;
        step_next = cmd.changed ? S_C0 : after_set;
      end
      S_C0: begin
        byte_next = gpbd_pkg::colour_byte(3'd0, cmd.grey);
        step_next = S_C1;
      end
      S_C1: begin
        byte_next = gpbd_pkg::colour_byte(3'd1, cmd.grey);
        step_next = S_C2;
      end
      S_C2: begin
        byte_next = gpbd_pkg::colour_byte(3'd2, cmd.grey);
        step_next = S_C3;
      end
      S_C3: begin
        byte_next = gpbd_pkg::colour_byte(3'd3, cmd.grey);
        step_next = S_C4;
      end
      S_C4: begin
        byte_next = gpbd_pkg::colour_byte(3'd4, cmd.grey);
        step_next = S_ALPHA;
      end
      S_ALPHA: begin
        byte_next = gpbd_pkg::CMD_ALPHA_FULL;
        step_next = S_SET;
      end
      S_SET: begin
        byte_next = gpbd_pkg::CMD_SET_RGBA;
        step_next = after_set;
      end
      S_NL1: begin
        byte_next = gpbd_pkg::CMD_DOWN_ONE;
        step_next = S_NL2;
      end
      S_NL2: begin
        byte_next = gpbd_pkg::CMD_TARGETX_ZERO;
        step_next = S_IDLE;
      end
      default: begin
        step_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= q_data;
      rem <= q_data.len;
    end else if (advance) begin
      rem <= rem_next;
    end
    if (advance) begin
      out_byte    <= byte_next;
      last_of_run <= step_next == S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) step <= step_start;
      else if (advance) step <= step_next;
    end
  end

endmodule

// ===== tb/sv/grey_pixels_to_block_draw_commands_tb.sv =====
`timescale 1ns / 1ps

module grey_pixels_to_block_draw_commands_tb;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       last;
    logic [7:0] value;
  } cmd_byte_t;

  class draw_cmd_scoreboard;
    logic [gpbd_pkg::DIM_W-1:0] width_reg;
    logic [gpbd_pkg::DIM_W-1:0] height_reg;
    logic [8:0]                 prev_grey;
    logic [gpbd_pkg::DIM_W-1:0] run_len;
    logic [gpbd_pkg::DIM_W-1:0] col_cnt;
    logic [gpbd_pkg::DIM_W-1:0] row_cnt;
    cmd_byte_t                  expected_bytes[$];
    int                         errors;

    function new();
      width_reg  = gpbd_pkg::DIM_W'(1);
      height_reg = gpbd_pkg::DIM_W'(1);
      prev_grey  = 9'd256;
      run_len    = '0;
      col_cnt    = '0;
      row_cnt    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [gpbd_pkg::DIM_W-1:0] data);
      if (idx == gpbd_pkg::REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == gpbd_pkg::REG_IMAGE_HEIGHT) height_reg = data;
    endfunction

    function int clamp(logic [gpbd_pkg::DIM_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function void add_byte(logic [7:0] b);
      cmd_byte_t e;
      e.last  = 1'b0;
      e.value = b;
      expected_bytes.push_back(e);
    endfunction

    function void note_pixel(logic [7:0] g);
      int        w;
      int        h;
      int        len;
      int        first_idx;
      logic      first_col;
      logic      last_col;
      logic      changed;
      logic [23:0] rgb;
      cmd_byte_t e;
      w = clamp(width_reg, gpbd_pkg::MAX_WIDTH);
      h = clamp(height_reg, gpbd_pkg::MAX_HEIGHT);
      first_idx = expected_bytes.size();
      first_col = (col_cnt == 0);
      last_col  = (int'(col_cnt) + 1 >= w);
      if (first_col && row_cnt == 0) begin
        add_byte(gpbd_pkg::CMD_BLOCK_TOOL);
        prev_grey = 9'd256;
      end
      changed = (prev_grey != {1'b0, g});
      if (changed || first_col || last_col) begin
        len = last_col ? int'(run_len) + 1 : int'(run_len);
        repeat (len / int'(gpbd_pkg::MOVE_STEP)) add_byte(gpbd_pkg::MOVE_STEP);
        if (len % int'(gpbd_pkg::MOVE_STEP) != 0)
          add_byte(8'(len % int'(gpbd_pkg::MOVE_STEP)));
        add_byte(gpbd_pkg::CMD_DOWN_ONE);
        add_byte(gpbd_pkg::CMD_UP_ONE);
        run_len = gpbd_pkg::DIM_W'(1);
        if (changed) begin
          rgb = {g, g, g};
          add_byte(8'(gpbd_pkg::CMD_COLOUR_BASE + rgb[23:22]));
          add_byte(8'(gpbd_pkg::CMD_COLOUR_BASE + rgb[21:16]));
          add_byte(8'(gpbd_pkg::CMD_COLOUR_BASE + rgb[15:10]));
          add_byte(8'(gpbd_pkg::CMD_COLOUR_BASE + rgb[9:4]));
          add_byte(8'(gpbd_pkg::CMD_COLOUR_BASE + {rgb[3:0], gpbd_pkg::ALPHA_LOW_BITS}));
          add_byte(gpbd_pkg::CMD_ALPHA_FULL);
          add_byte(gpbd_pkg::CMD_SET_RGBA);
        end
      end else begin
        run_len = run_len + 1'b1;
      end
      prev_grey = {1'b0, g};
      if (last_col) begin
        run_len = '0;
        add_byte(gpbd_pkg::CMD_DOWN_ONE);
        add_byte(gpbd_pkg::CMD_TARGETX_ZERO);
        col_cnt = '0;
        if (int'(row_cnt) + 1 >= h) row_cnt = '0;
        else row_cnt = row_cnt + 1'b1;
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
      if (expected_bytes.size() > first_idx) begin
        e = expected_bytes[expected_bytes.size() - 1];
        e.last = 1'b1;
        expected_bytes[expected_bytes.size() - 1] = e;
      end
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] b, logic l);
      cmd_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", b));
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.value) report($sformatf("out_byte %02h, expected %02h", b, e.value));
      if (l !== e.last) report($sformatf("last_of_run %b, expected %b", l, e.last));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = gpbd_pkg::REG_IMAGE_WIDTH;
  logic [gpbd_pkg::DIM_W-1:0] cfg_data = '0;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 pixel_value = 8'd0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [7:0]                 out_byte;
  logic                       last_of_run;

  draw_cmd_scoreboard sb;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  grey_pixels_to_block_draw_commands DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: check each transfer, then pick pop from a changing pattern
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_byte(out_byte, last_of_run);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (stall_tick % 5 != 0);
    endcase
  end

  task send_pixel(input logic [7:0] g);
    push <= 1'b1;
    pixel_value <= g;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_pixel(g);
  endtask

  // sender works in bursts with random gaps between them
  task feed(input logic [7:0] g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_pixel(g);
  endtask

  task settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_size(input logic [gpbd_pkg::DIM_W-1:0] w, input logic [gpbd_pkg::DIM_W-1:0] h,
                input bit with_spare);
    logic [1:0]                 spare;
    logic [gpbd_pkg::DIM_W-1:0] junk;
    cfg_we <= 1'b1;
    cfg_index <= gpbd_pkg::REG_IMAGE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    sb.write_reg(gpbd_pkg::REG_IMAGE_WIDTH, w);
    cfg_index <= gpbd_pkg::REG_IMAGE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    sb.write_reg(gpbd_pkg::REG_IMAGE_HEIGHT, h);
    if (with_spare || $urandom_range(0, 2) == 0) begin
      spare = $urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3;
      junk = gpbd_pkg::DIM_W'($urandom_range(0, 2047));
      cfg_index <= spare;
      cfg_data <= junk;
      @(posedge clk);
      sb.write_reg(spare, junk);
    end
    cfg_we <= 1'b0;
  endtask

  function logic [7:0] next_grey(input logic [7:0] prev, input int stay_pct);
    if ($urandom_range(0, 99) < stay_pct) return prev;
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int                         phase;
    int                         i;
    int                         stay;
    logic [gpbd_pkg::DIM_W-1:0] w;
    logic [gpbd_pkg::DIM_W-1:0] h;
    logic [7:0]                 g;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sizes straight out of reset: every pixel is a whole frame
    feed(8'h00);
    feed(8'hFF);
    settle();
    // zero sizes act as one, plus a write to an unused index
    set_size(gpbd_pkg::DIM_W'(0), gpbd_pkg::DIM_W'(0), 1'b1);
    feed(8'h55);
    settle();
    set_size(gpbd_pkg::DIM_W'(5), gpbd_pkg::DIM_W'(2), 1'b0);
    feed(8'hAA); feed(8'hAA); feed(8'hAA); feed(8'h0F); feed(8'hF0);
    feed(8'h01); feed(8'h01); feed(8'h80); feed(8'h80); feed(8'h80);
    feed(8'hFE);
    settle();
    // oversize registers saturate; leave the row open, then shrink under it
    set_size(gpbd_pkg::DIM_W'(2047), gpbd_pkg::DIM_W'(1025), 1'b0);
    repeat (6) feed(8'h33);
    settle();
    set_size(gpbd_pkg::DIM_W'(3), gpbd_pkg::DIM_W'(2047), 1'b0);
    feed(8'h33);
    feed(8'h33);

    g = 8'h00;
    for (phase = 0; phase < 10; phase++) begin
      settle();
      case (phase)
        0: begin
          w = gpbd_pkg::DIM_W'(2047);
          h = gpbd_pkg::DIM_W'($urandom_range(1, 4));
        end
        1: begin
          w = gpbd_pkg::DIM_W'($urandom_range(2, 40));
          h = gpbd_pkg::DIM_W'($urandom_range(1, 6));
        end
        9: begin
          w = gpbd_pkg::DIM_W'(1024);
          h = gpbd_pkg::DIM_W'(1024);
        end
        default: begin
          case ($urandom_range(0, 9))
            0: w = gpbd_pkg::DIM_W'(0);
            1: w = gpbd_pkg::DIM_W'(1);
            2: w = gpbd_pkg::DIM_W'(2);
            3: w = gpbd_pkg::DIM_W'($urandom_range(1025, 2047));
            4: w = gpbd_pkg::DIM_W'(31);
            5: w = gpbd_pkg::DIM_W'(32);
            default: w = gpbd_pkg::DIM_W'($urandom_range(1, 40));
          endcase
          case ($urandom_range(0, 5))
            0: h = gpbd_pkg::DIM_W'(0);
            1: h = gpbd_pkg::DIM_W'(1);
            2: h = gpbd_pkg::DIM_W'(2047);
            default: h = gpbd_pkg::DIM_W'($urandom_range(1, 6));
          endcase
        end
      endcase
      set_size(w, h, 1'b0);
      // long single-grey run, closed by the smaller width of the next phase
      if (phase == 0) begin
        g = 8'($urandom_range(0, 255));
        repeat (75) feed(g);
      end
      stay = $urandom_range(30, 95);
      for (i = 0; i < 32; i++) begin
        if (phase == 4 && i == 18) settle();
        g = next_grey(g, stay);
        feed(g);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grey_pixels_to_block_draw_commands regression: pass");
    end else begin
      $display("grey_pixels_to_block_draw_commands regression: fail");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("grey_pixels_to_block_draw_commands regression: fail");
    $finish;
  end

endmodule
